[rtl/omni_drive_heading_mixer_assert.svh]
// Assertion macros for the omni drive heading mixer.
`ifndef OMNI_DRIVE_HEADING_MIXER_ASSERT_SVH
`define OMNI_DRIVE_HEADING_MIXER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("omni drive heading mixer: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("omni drive heading mixer: next-cycle check failed");

`endif

[rtl/ohm_pkg.sv]
// Types, constants and table builders used by the heading mixer top level.
package ohm_pkg;

  localparam int unsigned DEG_FULL    = 360;
  localparam int unsigned DEG_HALF    = 180;
  localparam int unsigned DEG_QUARTER = 90;
  localparam int unsigned DEG_EIGHTH  = 45;

  localparam int unsigned MOD360_MUL   = 11651;
  localparam int unsigned MOD360_SHIFT = 22;
  localparam int unsigned ANGLE_BIAS   = 33120;

  localparam int unsigned E_MAX     = 89;
  localparam int unsigned E_NEAR    = 2;
  localparam int unsigned E_MID     = 6;
  localparam int unsigned SPIN_DEAD = 5;
  localparam int unsigned SPIN_SLOW = 20;
  localparam int unsigned GAIN_FRAC = 16;

  localparam int unsigned TAN_N = 46;
  localparam int unsigned TAN_W = 25;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [1:0] {
    BAND_NEAR,
    BAND_MID,
    BAND_FAR
  } gain_band_e;

  typedef enum logic {
    REG_MAX_POWER    = 1'b0,
    REG_HEADING_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       spin;
    logic [8:0] rel;
    logic [1:0] quarter;
    logic       sign_l;
    logic       sign_r;
    logic       wlow;
  } mix_ctl_t;

  typedef logic [TAN_N-1:0][TAN_W-1:0] tan_lut_t;

  function automatic logic [8:0] mod360(input logic [16:0] x);
    logic [30:0] prod;
    logic [8:0]  quo;
    logic [17:0] rem;
    prod = 31'(x) * 31'(MOD360_MUL);
    quo  = 9'(prod >> MOD360_SHIFT);
    rem  = 18'(x) - 18'(quo) * 18'(DEG_FULL);
    if (rem >= 18'(DEG_FULL)) begin
      rem = rem - 18'(DEG_FULL);
    end
    return rem[8:0];
  endfunction

  // Long division by shift and subtract, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Elaboration-time build of the tangent table from a Q2.30 series.
  function automatic tan_lut_t tan_table(input int unsigned fbits);
    tan_lut_t    t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] st;
    logic [63:0] ss;
    logic [63:0] ct;
    logic [63:0] cs;
    t = '0;
    for (int k = 1; k < 45; k++) begin
      x  = udiv64(64'(k) * PI_Q30 + 64'd90, 64'd180);
      x2 = (x * x) >> 30;
      st = x;
      ss = x;
      ct = ONE_Q30;
      cs = ONE_Q30;
      for (int n = 1; n <= 6; n++) begin
        st = udiv64((st * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        ct = udiv64((ct * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
        if ((n & 1) == 1) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      t[k] = TAN_W'(udiv64(ss << fbits, cs));
    end
    t[45] = TAN_W'(64'd1 << fbits);
    return t;
  endfunction

endpackage

[rtl/ohm_div.sv]
// Pipelined restoring divider computing two quotients in lockstep with a side payload.
module ohm_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 22,
  parameter int unsigned QW = 21,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [NW-1:0] dvd_a_i,
  input  logic [DW-1:0] dsr_a_i,
  input  logic [NW-1:0] dvd_b_i,
  input  logic [DW-1:0] dsr_b_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [QW-1:0] quo_a_o,
  output logic [QW-1:0] quo_b_o,
  output logic [PW-1:0] pay_o
);

  localparam int unsigned CW = NW + DW + QW;

  logic [QW-1:0] v_q;
  logic [QW:0]   rdy;
  logic [NW-1:0] rem_a_q [QW];
  logic [NW-1:0] rem_b_q [QW];
  logic [DW-1:0] dsr_a_q [QW];
  logic [DW-1:0] dsr_b_q [QW];
  logic [QW-1:0] quo_a_q [QW];
  logic [QW-1:0] quo_b_q [QW];
  logic [PW-1:0] pay_q   [QW];

  assign rdy[QW] = !stall_i;
  assign stall_o = !rdy[0];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rem_a_in;
    logic [NW-1:0] rem_b_in;
    logic [DW-1:0] dsr_a_in;
    logic [DW-1:0] dsr_b_in;
    logic [QW-1:0] quo_a_in;
    logic [QW-1:0] quo_b_in;
    logic [PW-1:0] pay_in;
    logic [CW-1:0] trial_a;
    logic [CW-1:0] trial_b;
    logic          fit_a;
    logic          fit_b;

    if (j == 0) begin : g_first
      assign v_in     = valid_i;
      assign rem_a_in = dvd_a_i;
      assign rem_b_in = dvd_b_i;
      assign dsr_a_in = dsr_a_i;
      assign dsr_b_in = dsr_b_i;
      assign quo_a_in = '0;
      assign quo_b_in = '0;
      assign pay_in   = pay_i;
    end else begin : g_next
      assign v_in     = v_q[j-1];
      assign rem_a_in = rem_a_q[j-1];
      assign rem_b_in = rem_b_q[j-1];
      assign dsr_a_in = dsr_a_q[j-1];
      assign dsr_b_in = dsr_b_q[j-1];
      assign quo_a_in = quo_a_q[j-1];
      assign quo_b_in = quo_b_q[j-1];
      assign pay_in   = pay_q[j-1];
    end

    assign trial_a = CW'(dsr_a_in) << (QW - 1 - j);
    assign trial_b = CW'(dsr_b_in) << (QW - 1 - j);
    assign fit_a   = CW'(rem_a_in) >= trial_a;
    assign fit_b   = CW'(rem_b_in) >= trial_b;
    assign rdy[j]  = !v_q[j] || rdy[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        rem_a_q[j] <= fit_a ? NW'(CW'(rem_a_in) - trial_a) : rem_a_in;
        rem_b_q[j] <= fit_b ? NW'(CW'(rem_b_in) - trial_b) : rem_b_in;
        dsr_a_q[j] <= dsr_a_in;
        dsr_b_q[j] <= dsr_b_in;
        quo_a_q[j] <= quo_a_in | (fit_a ? (QW'(1) << (QW - 1 - j)) : QW'(0));
        quo_b_q[j] <= quo_b_in | (fit_b ? (QW'(1) << (QW - 1 - j)) : QW'(0));
        pay_q[j]   <= pay_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_a_o = quo_a_q[QW-1];
  assign quo_b_o = quo_b_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule

[rtl/omni_drive_heading_mixer.sv]
// Top level of the omni drive heading mixer: angle reduction, tangent table, divider, mixing.
//
// Commands arrive on the input channel (valid_i, stall_o) as heading, move angle and front
// angle; one beat of four signed wheel powers leaves on the output channel (valid_o, stall_i)
// for every command, in order. A move angle of -1 selects spin in place.
// Every stage holds a valid bit and moves on when the stage after it is empty or moving, so a
// new command is taken in every cycle unless the output stalls, and bubbles close up behind
// a stalled output. The pipeline holds six stages of angle reduction, heading error, table
// lookup and magnitude scaling, FRACTION_BITS + 6 stages of the restoring divider that forms
// the heading factor and its reciprocal, one multiply stage and the output register.
// Throughput is one command per cycle while the output is not stalled.
// When the receiver stalls, the output beat holds and the pipeline fills; stall_o rises only
// once the first stage holds a command that cannot move.
// Reset empties the pipeline and sets max_power to 255 and heading_gain to 1638. The
// configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes a register; the user must
// use it only while no command is in flight, as the block itself does not enforce this.
`include "omni_drive_heading_mixer_assert.svh"

module omni_drive_heading_mixer #(
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic        [13:0] cfg_data_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic        [8:0]  heading_i,
  input  logic signed [15:0] move_angle_i,
  input  logic signed [15:0] front_angle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] power_front_right_o,
  output logic signed [15:0] power_back_right_o,
  output logic signed [15:0] power_back_left_o,
  output logic signed [15:0] power_front_left_o
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned RW   = F + 1;
  localparam int unsigned MW   = F + 9;
  localparam int unsigned QW   = F + 6;
  localparam int unsigned DNW  = 22;
  localparam int unsigned DDW  = 19;
  localparam int unsigned NW   = DNW + F;
  localparam int unsigned PRW  = MW + QW;
  localparam int unsigned MAGW = 15;
  localparam int unsigned CTLW = $bits(ohm_pkg::mix_ctl_t);
  localparam int unsigned PW   = CTLW + 2 * MW;

  localparam ohm_pkg::tan_lut_t TAN_LUT = ohm_pkg::tan_table(FRACTION_BITS);

  localparam logic signed [11:0] S_FULL = 12'(ohm_pkg::DEG_FULL);
  localparam logic signed [11:0] S_HALF = 12'(ohm_pkg::DEG_HALF);
  localparam logic signed [11:0] S_EMAX = 12'(ohm_pkg::E_MAX);

  // Configuration registers.
  logic [7:0]  max_power_q;
  logic [13:0] heading_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q    <= 8'd255;
      heading_gain_q <= 14'd1638;
    end else if (cfg_we_i) begin
      case (ohm_pkg::cfg_reg_e'(cfg_index_i))
        ohm_pkg::REG_MAX_POWER:    max_power_q    <= cfg_data_i[7:0];
        ohm_pkg::REG_HEADING_GAIN: heading_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake chain.
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy_p1, rdy_out;
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, p1_v_q, out_v_q;
  logic div_v, div_stall_in;

  assign rdy_out = !out_v_q || !stall_i;
  assign rdy_p1  = !p1_v_q || rdy_out;
  assign rdy5    = !s5_v_q || !div_stall_in;
  assign rdy4    = !s4_v_q || rdy5;
  assign rdy3    = !s3_v_q || rdy4;
  assign rdy2    = !s2_v_q || rdy3;
  assign rdy1    = !s1_v_q || rdy2;
  assign rdy0    = !s0_v_q || rdy1;
  assign stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0)    s0_v_q  <= valid_i;
      if (rdy1)    s1_v_q  <= s0_v_q;
      if (rdy2)    s2_v_q  <= s1_v_q;
      if (rdy3)    s3_v_q  <= s2_v_q;
      if (rdy4)    s4_v_q  <= s3_v_q;
      if (rdy5)    s5_v_q  <= s4_v_q;
      if (rdy_p1)  p1_v_q  <= div_v;
      if (rdy_out) out_v_q <= p1_v_q;
    end
  end

  // Stage 0: input register.
  logic        [8:0]  s0_h_q;
  logic signed [15:0] s0_mv_q;
  logic signed [15:0] s0_f_q;

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      s0_h_q  <= heading_i;
      s0_mv_q <= move_angle_i;
      s0_f_q  <= front_angle_i;
    end
  end

  // Stage 1: angle reduction.
  logic [8:0]  s1_c_d, s1_fm_d, s1_mvm_d;
  logic [8:0]  s1_c_q, s1_fm_q, s1_mvm_q;
  logic        s1_spin_q;
  logic [16:0] s1_fb, s1_mb;

  always_comb begin
    s1_c_d   = (s0_h_q >= 9'(ohm_pkg::DEG_FULL)) ? s0_h_q - 9'(ohm_pkg::DEG_FULL) : s0_h_q;
    s1_fb    = 17'({s0_f_q[15], s0_f_q}) + 17'(ohm_pkg::ANGLE_BIAS);
    s1_mb    = 17'({s0_mv_q[15], s0_mv_q}) + 17'(ohm_pkg::ANGLE_BIAS);
    s1_fm_d  = ohm_pkg::mod360(s1_fb);
    s1_mvm_d = ohm_pkg::mod360(s1_mb);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_c_q    <= s1_c_d;
      s1_fm_q   <= s1_fm_d;
      s1_mvm_q  <= s1_mvm_d;
      s1_spin_q <= (s0_mv_q == -16'sd1);
    end
  end

  // Stage 2: quarter turn, heading error and relative heading.
  logic        [1:0]  s2_q_d, s2_q_q;
  logic        [6:0]  s2_e_d, s2_e_q;
  logic        [8:0]  s2_rel_d, s2_rel_q;
  logic        [8:0]  s2_c_q, s2_mvm_q;
  logic               s2_spin_q;
  logic signed [11:0] cs, rs, es;
  logic        [10:0] rt;

  always_comb begin
    if (s1_c_q < 9'(ohm_pkg::DEG_EIGHTH) ||
        s1_c_q > 9'(ohm_pkg::DEG_FULL - ohm_pkg::DEG_EIGHTH)) begin
      s2_q_d = 2'd0;
    end else if (s1_c_q < 9'(ohm_pkg::DEG_QUARTER + ohm_pkg::DEG_EIGHTH)) begin
      s2_q_d = 2'd1;
    end else if (s1_c_q <= 9'(ohm_pkg::DEG_HALF + ohm_pkg::DEG_EIGHTH)) begin
      s2_q_d = 2'd2;
    end else begin
      s2_q_d = 2'd3;
    end

    cs = 12'(s1_c_q);
    rs = S_FULL - 12'(s1_fm_q);
    if (rs < S_HALF) begin
      if (cs >= rs && cs < rs + S_HALF) es = cs - rs;
      else if (cs < rs)                 es = rs - cs;
      else                              es = rs + S_FULL - cs;
    end else begin
      if (cs <= rs && cs > rs - S_HALF) es = rs - cs;
      else if (cs < rs - S_HALF)        es = S_FULL - rs + cs;
      else                              es = cs - rs;
    end
    if (es <= 12'sd0)      s2_e_d = 7'd0;
    else if (es > S_EMAX)  s2_e_d = 7'(ohm_pkg::E_MAX);
    else                   s2_e_d = es[6:0];

    rt = 11'(2 * ohm_pkg::DEG_FULL) - 11'(s1_c_q) - 11'(s1_fm_q);
    if (rt >= 11'(ohm_pkg::DEG_FULL)) rt = rt - 11'(ohm_pkg::DEG_FULL);
    if (rt >= 11'(ohm_pkg::DEG_FULL)) rt = rt - 11'(ohm_pkg::DEG_FULL);
    s2_rel_d = rt[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_q_q    <= s2_q_d;
      s2_e_q    <= s2_e_d;
      s2_rel_q  <= s2_rel_d;
      s2_c_q    <= s1_c_q;
      s2_mvm_q  <= s1_mvm_q;
      s2_spin_q <= s1_spin_q;
    end
  end

  // Stage 3: travel direction and heading factor operands.
  logic [8:0]     s3_ang_d, s3_ang_q;
  logic [DNW-1:0] s3_dnum_d, s3_dnum_q;
  logic [DDW-1:0] s3_dden_d, s3_dden_q;
  logic [1:0]     s3_q_q;
  logic [8:0]     s3_rel_q;
  logic           s3_spin_q;
  logic [11:0]    asum;
  logic [20:0]    eg;
  logic [22:0]    egn;
  ohm_pkg::gain_band_e band;

  always_comb begin
    asum = 12'(ohm_pkg::DEG_EIGHTH) + 12'(s2_c_q) + 12'(s2_mvm_q)
         + 12'(2 * ohm_pkg::DEG_FULL) - 12'(ohm_pkg::DEG_QUARTER) * 12'(s2_q_q);
    s3_ang_d = ohm_pkg::mod360(17'(asum));

    if (s2_e_q < 7'(ohm_pkg::E_NEAR))     band = ohm_pkg::BAND_NEAR;
    else if (s2_e_q < 7'(ohm_pkg::E_MID)) band = ohm_pkg::BAND_MID;
    else                                  band = ohm_pkg::BAND_FAR;

    eg = 21'(s2_e_q) * 21'(heading_gain_q);
    case (band)
      ohm_pkg::BAND_NEAR: begin
        egn       = 23'(eg) + (23'(eg) << 1);
        s3_dden_d = DDW'(5) << ohm_pkg::GAIN_FRAC;
      end
      ohm_pkg::BAND_MID: begin
        egn       = 23'(eg) + (23'(eg) << 1);
        s3_dden_d = DDW'(2) << ohm_pkg::GAIN_FRAC;
      end
      default: begin
        egn       = 23'(eg) << 1;
        s3_dden_d = DDW'(1) << ohm_pkg::GAIN_FRAC;
      end
    endcase
    s3_dnum_d = DNW'(23'(s3_dden_d) + egn);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_ang_q  <= s3_ang_d;
      s3_dnum_q <= s3_dnum_d;
      s3_dden_q <= s3_dden_d;
      s3_q_q    <= s2_q_q;
      s3_rel_q  <= s2_rel_q;
      s3_spin_q <= s2_spin_q;
    end
  end

  // Stage 4: diagonal ratios from the tangent table.
  logic [RW-1:0]  s4_nl_d, s4_nr_d, s4_nl_q, s4_nr_q;
  ohm_pkg::mix_ctl_t s4_ctl_d, s4_ctl_q;
  logic [DNW-1:0] s4_dnum_q;
  logic [DDW-1:0] s4_dden_q;
  logic [8:0]     ref_a;
  logic [6:0]     ref_r;
  logic [5:0]     tk;
  logic [RW-1:0]  tv;

  always_comb begin
    ref_a = (s3_ang_q >= 9'(ohm_pkg::DEG_HALF)) ? s3_ang_q - 9'(ohm_pkg::DEG_HALF) : s3_ang_q;
    if (ref_a > 9'(ohm_pkg::DEG_QUARTER)) ref_a = 9'(ohm_pkg::DEG_HALF) - ref_a;
    ref_r = ref_a[6:0];
    if (ref_r <= 7'(ohm_pkg::DEG_EIGHTH)) tk = ref_r[5:0];
    else                                  tk = 6'(7'(ohm_pkg::DEG_QUARTER) - ref_r);
    tv = TAN_LUT[tk][RW-1:0];
    if (ref_r <= 7'(ohm_pkg::DEG_EIGHTH)) begin
      s4_nl_d = tv;
      s4_nr_d = RW'(1) << F;
    end else begin
      s4_nl_d = RW'(1) << F;
      s4_nr_d = tv;
    end
    s4_ctl_d.spin    = s3_spin_q;
    s4_ctl_d.rel     = s3_rel_q;
    s4_ctl_d.quarter = s3_q_q;
    s4_ctl_d.sign_l  = (s3_ang_q > 9'(ohm_pkg::DEG_HALF)) && (s4_nl_d != '0);
    s4_ctl_d.sign_r  = (s3_ang_q > 9'(ohm_pkg::DEG_QUARTER)) &&
                       (s3_ang_q < 9'(ohm_pkg::DEG_HALF + ohm_pkg::DEG_QUARTER)) &&
                       (s4_nr_d != '0);
    s4_ctl_d.wlow    = s3_rel_q < 9'(ohm_pkg::DEG_HALF);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_nl_q   <= s4_nl_d;
      s4_nr_q   <= s4_nr_d;
      s4_ctl_q  <= s4_ctl_d;
      s4_dnum_q <= s3_dnum_q;
      s4_dden_q <= s3_dden_q;
    end
  end

  // Stage 5: magnitudes scaled by max_power.
  logic [MW-1:0]  s5_mag_l_q, s5_mag_r_q;
  ohm_pkg::mix_ctl_t s5_ctl_q;
  logic [DNW-1:0] s5_dnum_q;
  logic [DDW-1:0] s5_dden_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      if (s4_ctl_q.spin) begin
        s5_mag_l_q <= MW'(max_power_q) << F;
        s5_mag_r_q <= MW'(max_power_q) << F;
      end else begin
        s5_mag_l_q <= MW'(s4_nl_q) * MW'(max_power_q);
        s5_mag_r_q <= MW'(s4_nr_q) * MW'(max_power_q);
      end
      s5_ctl_q  <= s4_ctl_q;
      s5_dnum_q <= s4_dnum_q;
      s5_dden_q <= s4_dden_q;
    end
  end

  // Heading factor P and its reciprocal R.
  logic [QW-1:0] div_pq, div_rq;
  logic [PW-1:0] div_pay;

  ohm_div #(
    .NW (NW),
    .DW (DNW),
    .QW (QW),
    .PW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .stall_o (div_stall_in),
    .dvd_a_i (NW'(s5_dden_q) << F),
    .dsr_a_i (s5_dnum_q),
    .dvd_b_i (NW'(s5_dnum_q) << F),
    .dsr_b_i (DNW'(s5_dden_q)),
    .pay_i   ({s5_ctl_q, s5_mag_l_q, s5_mag_r_q}),
    .valid_o (div_v),
    .stall_i (!rdy_p1),
    .quo_a_o (div_pq),
    .quo_b_o (div_rq),
    .pay_o   (div_pay)
  );

  // Stage P1: products of magnitudes and factors.
  ohm_pkg::mix_ctl_t p1_ctl_q;
  logic [PRW-1:0] p1_lp_q, p1_lr_q, p1_rp_q, p1_rr_q;
  ohm_pkg::mix_ctl_t dp_ctl;
  logic [MW-1:0]  dp_ml, dp_mr;

  assign {dp_ctl, dp_ml, dp_mr} = div_pay;

  always_ff @(posedge clk_i) begin
    if (rdy_p1) begin
      p1_ctl_q <= dp_ctl;
      p1_lp_q  <= PRW'(dp_ml) * PRW'(div_pq);
      p1_lr_q  <= PRW'(dp_ml) * PRW'(div_rq);
      p1_rp_q  <= PRW'(dp_mr) * PRW'(div_pq);
      p1_rr_q  <= PRW'(dp_mr) * PRW'(div_rq);
    end
  end

  // Output stage: signs, spin bands and wheel remap.
  function automatic logic [15:0] signed_power(input logic [MAGW-1:0] m, input logic neg);
    return neg ? 16'(16'd0 - {1'b0, m}) : {1'b0, m};
  endfunction

  logic [MAGW-1:0] m_lp, m_lr, m_rp, m_rr;
  logic [15:0]     spin_a;
  logic [15:0]     lv [4];
  logic [15:0]     wheel_d [4];
  logic [15:0]     out_q [4];
  logic            sel_l, sel_r, flip;
  logic [1:0]      lidx;
  logic [1:0]      pq_q;

  always_comb begin
    m_lp  = p1_lp_q[PRW-1 -: MAGW];
    m_lr  = p1_lr_q[PRW-1 -: MAGW];
    m_rp  = p1_rp_q[PRW-1 -: MAGW];
    m_rr  = p1_rr_q[PRW-1 -: MAGW];
    pq_q  = p1_ctl_q.quarter;
    sel_l = (!p1_ctl_q.sign_l) == p1_ctl_q.wlow;
    sel_r = (!p1_ctl_q.sign_r) == p1_ctl_q.wlow;

    if (p1_ctl_q.rel <= 9'(ohm_pkg::SPIN_DEAD) ||
        p1_ctl_q.rel >= 9'(ohm_pkg::DEG_FULL - ohm_pkg::SPIN_DEAD)) begin
      spin_a = 16'd0;
    end else if (p1_ctl_q.rel <= 9'(ohm_pkg::SPIN_SLOW)) begin
      spin_a = signed_power(m_lp, 1'b1);
    end else if (p1_ctl_q.rel < 9'(ohm_pkg::DEG_HALF)) begin
      spin_a = signed_power(m_lr, 1'b1);
    end else if (p1_ctl_q.rel < 9'(ohm_pkg::DEG_FULL - ohm_pkg::SPIN_SLOW)) begin
      spin_a = signed_power(m_lr, 1'b0);
    end else begin
      spin_a = signed_power(m_lp, 1'b0);
    end

    if (p1_ctl_q.spin) begin
      lv[0] = spin_a;
      lv[1] = spin_a;
      lv[2] = 16'(16'd0 - spin_a);
      lv[3] = 16'(16'd0 - spin_a);
    end else begin
      lv[0] = signed_power(sel_l ? m_lp : m_lr, p1_ctl_q.sign_l);
      lv[2] = signed_power(sel_l ? m_lr : m_lp, p1_ctl_q.sign_l);
      lv[1] = signed_power(sel_r ? m_rp : m_rr, p1_ctl_q.sign_r);
      lv[3] = signed_power(sel_r ? m_rr : m_rp, p1_ctl_q.sign_r);
    end

    for (int r = 0; r < 4; r++) begin
      lidx = 2'(r) + pq_q;
      if ((r & 1) == 0) flip = (pq_q == 2'd2) || (pq_q == 2'd3);
      else              flip = (pq_q == 2'd1) || (pq_q == 2'd2);
      wheel_d[r] = flip ? 16'(16'd0 - lv[lidx]) : lv[lidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      for (int r = 0; r < 4; r++) begin
        out_q[r] <= wheel_d[r];
      end
    end
  end

  assign valid_o             = out_v_q;
  assign power_front_right_o = out_q[0];
  assign power_back_right_o  = out_q[1];
  assign power_back_left_o   = out_q[2];
  assign power_front_left_o  = out_q[3];

  `OHM_ASSERT_NOW(a_stall_only_when_held, stall_o, s0_v_q)
  `OHM_ASSERT_NOW(a_error_clamped, s2_v_q, s2_e_q <= 7'd89)
  `OHM_ASSERT_NOW(a_spin_magnitudes_equal, s5_v_q && s5_ctl_q.spin, s5_mag_l_q == s5_mag_r_q)
  `OHM_ASSERT_NEXT(a_product_reaches_output, p1_v_q && rdy_out, out_v_q)

endmodule
